### sv/difs_pkg.sv
// Package for the double integer/fraction split core: field widths and constants.
// No dependencies.
`default_nettype none
package difs_pkg;
    localparam int unsigned DataW  = 64;
    localparam int unsigned MantW  = 52;
    localparam int unsigned ExpW   = 11;
    localparam int unsigned UexpW  = 12;
    localparam int unsigned PosW   = 6;
    localparam logic [ExpW-1:0] ExpBias = 11'h3FF;

    typedef struct packed {
        logic signed [UexpW-1:0] unbiased_exponent;
        logic [DataW-1:0]        integer_part_bits;
        logic [DataW-1:0]        fraction_part_bits;
        logic [DataW-1:0]        significand_bits;
    } result_t;
endpackage
`default_nettype wire

### sv/difs_if.sv
// Valid/ready channel interfaces for the split core.
// Depends on difs_pkg.
`default_nettype none
interface difs_in_if;
    logic                      valid;
    logic                      ready;
    logic [difs_pkg::DataW-1:0] value_bits;
    modport source (output valid, output value_bits, input ready);
    modport sink   (input valid, input value_bits, output ready);
endinterface

interface difs_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [difs_pkg::UexpW-1:0]   unbiased_exponent;
    logic [difs_pkg::DataW-1:0]          integer_part_bits;
    logic [difs_pkg::DataW-1:0]          fraction_part_bits;
    logic [difs_pkg::DataW-1:0]          significand_bits;
    modport source (output valid, output unbiased_exponent, output integer_part_bits,
                    output fraction_part_bits, output significand_bits, input ready);
    modport sink   (input valid, input unbiased_exponent, input integer_part_bits,
                    input fraction_part_bits, input significand_bits, output ready);
endinterface
`default_nettype wire

### sv/difs_split.sv
// Combinational split of one double into exponent, integer, fraction, significand.
// Depends on difs_pkg.
`default_nettype none
module difs_split (
    input  wire logic [difs_pkg::DataW-1:0] x,
    output difs_pkg::result_t               res
);
    import difs_pkg::*;

    logic             sign;
    logic [ExpW-1:0]  field;
    logic [MantW-1:0] mant;
    logic [ExpW:0]    e;
    logic [PosW-1:0]  fb;
    logic [DataW-1:0] low;
    logic [MantW:0]   rem;
    logic [PosW-1:0]  p;
    logic [MantW:0]   norm;
    logic [ExpW-1:0]  bexp;

    always_comb
    begin
        sign  = x[DataW-1];
        field = x[DataW-2:MantW];
        mant  = x[MantW-1:0];
        e     = {1'b0, field} - {1'b0, ExpBias};
        fb    = PosW'(MantW) - e[PosW-1:0];
        low   = (DataW'(1) << fb) - DataW'(1);
        rem   = {1'b1, mant} & low[MantW:0];
        // leading-one position of the remainder
        p = '0;
        for (int i = 0; i <= MantW; i++)
        begin
            if (rem[i])
                p = PosW'(i);
        end
        norm = rem << (PosW'(MantW) - p);
        bexp = field - ExpW'(MantW) + ExpW'(p);

        res.unbiased_exponent  = signed'(e);
        res.significand_bits   = {sign, ExpBias, mant};
        if (field < ExpBias)
        begin
            res.integer_part_bits  = {sign, {(DataW-1){1'b0}}};
            res.fraction_part_bits = x;
        end
        else if (field >= ExpBias + ExpW'(MantW))
        begin
            res.integer_part_bits  = x;
            res.fraction_part_bits = {sign, {(DataW-1){1'b0}}};
        end
        else
        begin
            res.integer_part_bits = x & ~low;
            if (rem == '0)
                res.fraction_part_bits = {sign, {(DataW-1){1'b0}}};
            else
                res.fraction_part_bits = {sign, bexp, norm[MantW-1:0]};
        end
    end
endmodule
`default_nettype wire

### sv/double_integer_fraction_split_core.sv
// Top level of the double integer/fraction split core.
// Depends on difs_pkg, difs_if, difs_split.
//
//  channel | dir | payload
//  in_ch   | in  | value_bits
//  out_ch  | out | unbiased_exponent, integer_part_bits, fraction_part_bits, significand_bits
//
// One transaction per cycle while out_ch is not stalled; each passes the input register, then the result register.
// The split logic between the two registers sets the clock period.
// Reset clears the valid flags only. A stalled output holds the result register;
// the input register advances whenever the result register can take its content.
`default_nettype none
module double_integer_fraction_split_core (
    input wire logic   clk,
    input wire logic   rst_n,
    difs_in_if.sink    in_ch,
    difs_out_if.source out_ch
);
    import difs_pkg::*;

    logic             in_vld_reg;
    logic [DataW-1:0] in_data_reg;
    logic             out_vld_reg;
    result_t          out_data_reg;
    result_t          res_next;
    logic             out_load;
    logic             in_load;

    difs_split u_split (.x(in_data_reg), .res(res_next));

    assign out_load     = !out_vld_reg || out_ch.ready;
    assign in_load      = !in_vld_reg || out_load;
    assign in_ch.ready  = in_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_load)
                in_vld_reg <= in_ch.valid;
            if (out_load)
                out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load && in_ch.valid)
            in_data_reg <= in_ch.value_bits;
        if (out_load && in_vld_reg)
            out_data_reg <= res_next;
    end

    assign out_ch.valid              = out_vld_reg;
    assign out_ch.unbiased_exponent  = out_data_reg.unbiased_exponent;
    assign out_ch.integer_part_bits  = out_data_reg.integer_part_bits;
    assign out_ch.fraction_part_bits = out_data_reg.fraction_part_bits;
    assign out_ch.significand_bits   = out_data_reg.significand_bits;
endmodule
`default_nettype wire
